>>> rtl/ogr_pkg.sv
package ogr_pkg;

    // Grid geometry
    localparam int GRID_W   = 32;
    localparam int GRID_H   = 32;
    localparam int GRID_MAX = (GRID_W > GRID_H) ? GRID_W : GRID_H;
    localparam int GX_W     = $clog2(GRID_W);
    localparam int GY_W     = $clog2(GRID_H);
    localparam int GM_W     = $clog2(GRID_MAX);
    localparam int CELLS    = GRID_W * GRID_H;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int RG_W     = GM_W + 1;

    // Grid conversion numerator: 2p +/- size - 2*origin + n*cell_size
    localparam int NUM_SPAN = GRID_MAX * 4095 + 98302 + 65536;
    localparam int NUM_W    = $clog2(NUM_SPAN + 1);
    localparam int SW       = NUM_W + 1;
    localparam int CW       = NUM_W + 2;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);

    localparam logic signed [15:0] WORLD_MAX_X = 16'sd12800;
    localparam logic signed [15:0] WORLD_MAX_Y = 16'sd9600;

    // Request types
    localparam logic [2:0] REQ_CLR_LM  = 3'd0;
    localparam logic [2:0] REQ_POINT   = 3'd1;
    localparam logic [2:0] REQ_LINE    = 3'd2;
    localparam logic [2:0] REQ_CIRCLE  = 3'd3;
    localparam logic [2:0] REQ_RECT    = 3'd4;
    localparam logic [2:0] REQ_EXPLORE = 3'd5;
    localparam logic [2:0] REQ_QUERY   = 3'd6;
    localparam logic [2:0] REQ_CLR_ALL = 3'd7;

    // Configuration register indexes
    localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_X  = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Y  = 2'd2;

    // Cell states
    localparam logic [1:0] ST_UNKNOWN  = 2'd0;
    localparam logic [1:0] ST_EXPLORED = 2'd1;
    localparam logic [1:0] ST_OCCUPIED = 2'd2;

    // Back-end operations
    localparam logic [3:0] OP_SKIP    = 4'd0;
    localparam logic [3:0] OP_POINT   = 4'd1;
    localparam logic [3:0] OP_LINE    = 4'd2;
    localparam logic [3:0] OP_CIRC    = 4'd3;
    localparam logic [3:0] OP_RECT    = 4'd4;
    localparam logic [3:0] OP_EXPL    = 4'd5;
    localparam logic [3:0] OP_QUERY   = 4'd6;
    localparam logic [3:0] OP_CLR_LM  = 4'd7;
    localparam logic [3:0] OP_CLR_ALL = 4'd8;

    typedef struct packed {
        logic [1:0] st;
        logic       lm;
        logic [7:0] cnt;
        logic [7:0] conf;
    } t_cell;

    typedef struct packed {
        logic [11:0]        csz;
        logic signed [15:0] org_x;
        logic signed [15:0] org_y;
    } t_cfg;

    typedef struct packed {
        logic [3:0]         op;
        logic [GX_W-1:0]    x0;
        logic [GX_W-1:0]    x1;
        logic [GY_W-1:0]    y0;
        logic [GY_W-1:0]    y1;
        logic [7:0]         conf;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [14:0]        m;
    } t_cmd;

endpackage

>>> rtl/ogr_if.sv
interface ogr_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic               line_has_ends;
    logic [14:0]        size_x;
    logic [14:0]        size_y;
    logic [7:0]         confidence;

    modport source (output valid, req_type, pos_x, pos_y, end_x, end_y, line_has_ends,
                    size_x, size_y, confidence, input ready);
    modport sink (input valid, req_type, pos_x, pos_y, end_x, end_y, line_has_ends,
                  size_x, size_y, confidence, output ready);
endinterface

interface ogr_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] cell_state;
    logic       has_landmark;
    logic [7:0] landmark_count;
    logic [7:0] cell_confidence;

    modport source (output valid, cell_state, has_landmark, landmark_count, cell_confidence,
                    input ready);
    modport sink (input valid, cell_state, has_landmark, landmark_count, cell_confidence,
                  output ready);
endinterface

>>> rtl/ogr_front.sv
module ogr_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ogr_req_if.sink       i_req,
    input  ogr_pkg::t_cfg i_cfg,
    input  logic          i_hold,
    output ogr_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_LOAD = 2'd1;
    localparam logic [1:0] F_DIV  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;
    localparam int CNT_W = $clog2(ogr_pkg::NUM_W + 1);

    logic [1:0] r_state, n_state;

    logic [3:0]         r_op;
    logic signed [15:0] r_px, r_py, r_ex, r_ey;
    logic [14:0]        r_szx, r_szy;
    logic [7:0]         r_conf;
    logic [1:0]         r_k;
    logic [2:0]         r_nconv;

    logic [ogr_pkg::GM_W-1:0]  r_g [4];
    logic [ogr_pkg::RG_W-1:0]  r_rg;
    logic [12:0]               r_rem;
    logic [ogr_pkg::NUM_W-1:0] r_quo;
    logic                      r_neg;
    logic [CNT_W-1:0]          r_cnt;

    logic                       w_accept;
    logic                       w_skip;
    logic [3:0]                 w_op;
    logic [2:0]                 w_nconv;
    logic signed [15:0]         w_p, w_org;
    logic [14:0]                w_sz, w_m;
    logic [ogr_pkg::NUM_W-1:0]  w_nc, w_nc_x, w_nc_y, w_num_circ;
    logic signed [ogr_pkg::SW-1:0] w_p2, w_num_s;
    logic [13:0]                w_trial, w_d;
    logic [ogr_pkg::GM_W-1:0]   w_lim, w_gq;
    logic [ogr_pkg::RG_W-1:0]   w_rq;
    logic [ogr_pkg::RG_W-1:0]   w_clo, w_rlo;
    logic [ogr_pkg::RG_W:0]     w_chi, w_rhi;
    logic [ogr_pkg::GX_W-1:0]   w_xlo, w_xhi;
    logic [ogr_pkg::GY_W-1:0]   w_ylo, w_yhi;

    assign i_req.ready = (r_state == F_IDLE) && !i_hold;
    assign w_accept    = i_req.valid && i_req.ready;

    // Classify the incoming word
    always_comb begin
        w_skip = (i_req.pos_x < 16'sd0) || (i_req.pos_x > ogr_pkg::WORLD_MAX_X) ||
                 (i_req.pos_y < 16'sd0) || (i_req.pos_y > ogr_pkg::WORLD_MAX_Y);
        w_op    = ogr_pkg::OP_SKIP;
        w_nconv = 3'd0;
        unique case (i_req.req_type)
            ogr_pkg::REQ_CLR_LM: begin
                w_op = ogr_pkg::OP_CLR_LM;
            end
            ogr_pkg::REQ_CLR_ALL: begin
                w_op = ogr_pkg::OP_CLR_ALL;
            end
            ogr_pkg::REQ_LINE: begin
                if (i_req.line_has_ends) begin
                    w_op    = ogr_pkg::OP_LINE;
                    w_nconv = 3'd4;
                end else if (!w_skip) begin
                    w_op    = ogr_pkg::OP_POINT;
                    w_nconv = 3'd2;
                end
            end
            ogr_pkg::REQ_POINT: begin
                if (!w_skip) begin
                    w_op    = ogr_pkg::OP_POINT;
                    w_nconv = 3'd2;
                end
            end
            ogr_pkg::REQ_CIRCLE: begin
                w_op    = ogr_pkg::OP_CIRC;
                w_nconv = 3'd3;
            end
            ogr_pkg::REQ_RECT: begin
                w_op    = ogr_pkg::OP_RECT;
                w_nconv = 3'd4;
            end
            ogr_pkg::REQ_EXPLORE: begin
                w_op    = ogr_pkg::OP_EXPL;
                w_nconv = 3'd2;
            end
            ogr_pkg::REQ_QUERY: begin
                w_op    = ogr_pkg::OP_QUERY;
                w_nconv = 3'd2;
            end
            default: begin
                w_op = ogr_pkg::OP_SKIP;
            end
        endcase
    end

    // Numerator of the conversion for step r_k (even steps x, odd steps y)
    assign w_nc_x = ogr_pkg::NUM_W'(ogr_pkg::GRID_W) * ogr_pkg::NUM_W'(i_cfg.csz);
    assign w_nc_y = ogr_pkg::NUM_W'(ogr_pkg::GRID_H) * ogr_pkg::NUM_W'(i_cfg.csz);
    assign w_m    = (r_szx > r_szy) ? r_szx : r_szy;

    always_comb begin
        w_p = r_k[0] ? r_py : r_px;
        if ((r_op == ogr_pkg::OP_LINE) && r_k[1]) begin
            w_p = r_k[0] ? r_ey : r_ex;
        end
        w_sz  = r_k[0] ? r_szy : r_szx;
        w_org = r_k[0] ? i_cfg.org_y : i_cfg.org_x;
        w_nc  = r_k[0] ? w_nc_y : w_nc_x;
        w_p2  = ogr_pkg::SW'($signed({w_p, 1'b0}));
        if (r_op == ogr_pkg::OP_RECT) begin
            if (r_k[1]) begin
                w_p2 = w_p2 + ogr_pkg::SW'($signed({1'b0, w_sz}));
            end else begin
                w_p2 = w_p2 - ogr_pkg::SW'($signed({1'b0, w_sz}));
            end
        end
        w_num_s    = w_p2 - ogr_pkg::SW'($signed({w_org, 1'b0})) + $signed({1'b0, w_nc});
        w_num_circ = ogr_pkg::NUM_W'(w_m) + ogr_pkg::NUM_W'({i_cfg.csz, 1'b0})
                     - ogr_pkg::NUM_W'(1);
    end

    // One restoring-division step per cycle, divisor 2*cell_size
    assign w_d     = {1'b0, i_cfg.csz, 1'b0};
    assign w_trial = {r_rem, r_quo[ogr_pkg::NUM_W-1]};

    // Clamp the quotient into the grid
    always_comb begin
        w_lim = r_k[0] ? ogr_pkg::GM_W'(ogr_pkg::GRID_H - 1) :
                         ogr_pkg::GM_W'(ogr_pkg::GRID_W - 1);
        if (r_neg) begin
            w_gq = '0;
        end else if (r_quo > ogr_pkg::NUM_W'(w_lim)) begin
            w_gq = w_lim;
        end else begin
            w_gq = r_quo[ogr_pkg::GM_W-1:0];
        end
        if (r_quo > ogr_pkg::NUM_W'(ogr_pkg::GRID_MAX)) begin
            w_rq = ogr_pkg::RG_W'(ogr_pkg::GRID_MAX);
        end else begin
            w_rq = r_quo[ogr_pkg::RG_W-1:0];
        end
    end

    // Circle window around the center cell
    always_comb begin
        w_clo = (ogr_pkg::RG_W'(r_g[0]) >= r_rg) ? ogr_pkg::RG_W'(r_g[0]) - r_rg : '0;
        w_rlo = (ogr_pkg::RG_W'(r_g[1]) >= r_rg) ? ogr_pkg::RG_W'(r_g[1]) - r_rg : '0;
        w_chi = (ogr_pkg::RG_W+1)'(r_g[0]) + (ogr_pkg::RG_W+1)'(r_rg);
        w_rhi = (ogr_pkg::RG_W+1)'(r_g[1]) + (ogr_pkg::RG_W+1)'(r_rg);
        if (w_chi > (ogr_pkg::RG_W+1)'(ogr_pkg::GRID_W - 1)) begin
            w_chi = (ogr_pkg::RG_W+1)'(ogr_pkg::GRID_W - 1);
        end
        if (w_rhi > (ogr_pkg::RG_W+1)'(ogr_pkg::GRID_H - 1)) begin
            w_rhi = (ogr_pkg::RG_W+1)'(ogr_pkg::GRID_H - 1);
        end
        w_xlo = w_clo[ogr_pkg::GX_W-1:0];
        w_ylo = w_rlo[ogr_pkg::GY_W-1:0];
        w_xhi = w_chi[ogr_pkg::GX_W-1:0];
        w_yhi = w_rhi[ogr_pkg::GY_W-1:0];
    end

    // Build the command for the back end
    always_comb begin
        o_cmd      = '0;
        o_cmd.op   = r_op;
        o_cmd.conf = r_conf;
        o_cmd.px   = r_px;
        o_cmd.py   = r_py;
        o_cmd.m    = w_m;
        o_cmd.x0   = r_g[0][ogr_pkg::GX_W-1:0];
        o_cmd.y0   = r_g[1][ogr_pkg::GY_W-1:0];
        o_cmd.x1   = r_g[2][ogr_pkg::GX_W-1:0];
        o_cmd.y1   = r_g[3][ogr_pkg::GY_W-1:0];
        if (r_op == ogr_pkg::OP_CIRC) begin
            o_cmd.x0 = w_xlo;
            o_cmd.x1 = w_xhi;
            o_cmd.y0 = w_ylo;
            o_cmd.y1 = w_yhi;
        end else if ((r_op == ogr_pkg::OP_CLR_LM) || (r_op == ogr_pkg::OP_CLR_ALL)) begin
            o_cmd.x0 = '0;
            o_cmd.y0 = '0;
            o_cmd.x1 = ogr_pkg::GX_W'(ogr_pkg::GRID_W - 1);
            o_cmd.y1 = ogr_pkg::GY_W'(ogr_pkg::GRID_H - 1);
        end
    end

    assign o_cmd_valid = (r_state == F_PUSH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (w_accept) begin
                    n_state = (w_nconv == 3'd0) ? F_PUSH : F_LOAD;
                end
            end
            F_LOAD: begin
                n_state = F_DIV;
            end
            F_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ({1'b0, r_k} + 3'd1 == r_nconv) ? F_PUSH : F_LOAD;
                end
            end
            F_PUSH: begin
                if (i_cmd_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= w_op;
            r_px    <= i_req.pos_x;
            r_py    <= i_req.pos_y;
            r_ex    <= i_req.end_x;
            r_ey    <= i_req.end_y;
            r_szx   <= i_req.size_x;
            r_szy   <= i_req.size_y;
            r_conf  <= i_req.confidence;
            r_nconv <= w_nconv;
            r_k     <= 2'd0;
        end
        if (r_state == F_LOAD) begin
            r_rem <= '0;
            r_cnt <= CNT_W'(ogr_pkg::NUM_W);
            if ((r_op == ogr_pkg::OP_CIRC) && (r_k == 2'd2)) begin
                r_neg <= 1'b0;
                r_quo <= w_num_circ;
            end else begin
                r_neg <= w_num_s[ogr_pkg::SW-1];
                r_quo <= w_num_s[ogr_pkg::NUM_W-1:0];
            end
        end
        if (r_state == F_DIV) begin
            if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (w_trial >= w_d) begin
                    r_rem <= 13'(w_trial - w_d);
                    r_quo <= {r_quo[ogr_pkg::NUM_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial[12:0];
                    r_quo <= {r_quo[ogr_pkg::NUM_W-2:0], 1'b0};
                end
            end else begin
                if ((r_op == ogr_pkg::OP_CIRC) && (r_k == 2'd2)) begin
                    r_rg <= w_rq;
                end else begin
                    r_g[r_k] <= w_gq;
                end
                r_k <= r_k + 2'd1;
            end
        end
    end

endmodule

>>> rtl/ogr_fifo.sv
module ogr_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ogr_pkg::t_cmd i_data,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ogr_pkg::t_cmd o_data
);

    ogr_pkg::t_cmd                 r_mem [ogr_pkg::QDEPTH];
    logic [ogr_pkg::QPTR_W-1:0]    r_wp, r_rp;
    logic [ogr_pkg::QPTR_W:0]      r_cnt;
    logic                          w_push, w_pop;

    assign o_push_ready = (r_cnt != (ogr_pkg::QPTR_W+1)'(ogr_pkg::QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_data       = r_mem[r_rp];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == ogr_pkg::QPTR_W'(ogr_pkg::QDEPTH - 1)) ? '0 :
                        r_wp + ogr_pkg::QPTR_W'(1);
            end
            if (w_pop) begin
                r_rp <= (r_rp == ogr_pkg::QPTR_W'(ogr_pkg::QDEPTH - 1)) ? '0 :
                        r_rp + ogr_pkg::QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + (ogr_pkg::QPTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - (ogr_pkg::QPTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> rtl/ogr_back.sv
module ogr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ogr_pkg::t_cfg i_cfg,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  ogr_pkg::t_cmd i_cmd,
    ogr_rsp_if.source     o_rsp,
    output logic          o_clearing
);

    localparam logic [2:0] B_INIT = 3'd0;
    localparam logic [2:0] B_IDLE = 3'd1;
    localparam logic [2:0] B_RD   = 3'd2;
    localparam logic [2:0] B_WR   = 3'd3;
    localparam logic [2:0] B_DONE = 3'd4;
    localparam int E_W = ogr_pkg::GM_W + 3;

    logic [2:0] r_state, n_state;

    ogr_pkg::t_cell r_mem [ogr_pkg::CELLS];
    ogr_pkg::t_cell r_rdata;

    ogr_pkg::t_cmd             r_cmd;
    logic [ogr_pkg::GX_W-1:0]  r_x;
    logic [ogr_pkg::GY_W-1:0]  r_y;
    logic signed [E_W-1:0]     r_err, r_dx, r_dy;
    logic                      r_sx, r_sy;
    logic [14:0]               r_ax, r_ay;
    logic                      r_far;
    logic [29:0]               r_mm;
    ogr_pkg::t_cell            r_res;
    ogr_pkg::t_cell            r_out;
    logic                      r_out_valid;

    logic [ogr_pkg::ADDR_W-1:0] w_addr;
    logic                       w_pop, w_load_out;
    logic                       w_last_x, w_last_y, w_raster_done;
    logic signed [ogr_pkg::CW-1:0] w_wx, w_wy;
    logic [ogr_pkg::CW-1:0]     w_abx, w_aby;
    logic [30:0]                w_d2;
    logic                       w_hit, w_we, w_done;
    ogr_pkg::t_cell             w_wdata;
    logic signed [E_W:0]        w_e2;
    logic signed [E_W-1:0]      w_err;
    logic [ogr_pkg::GX_W-1:0]   w_nx;
    logic [ogr_pkg::GY_W-1:0]   w_ny;

    function automatic ogr_pkg::t_cell f_mark(ogr_pkg::t_cell c, logic [7:0] conf);
        ogr_pkg::t_cell r;
        r    = c;
        r.st = ogr_pkg::ST_OCCUPIED;
        r.lm = 1'b1;
        if (c.cnt != 8'hff) begin
            r.cnt = c.cnt + 8'd1;
        end
        if (conf > c.conf) begin
            r.conf = conf;
        end
        return r;
    endfunction

    function automatic ogr_pkg::t_cell f_explore(ogr_pkg::t_cell c, logic [7:0] conf);
        ogr_pkg::t_cell r;
        r = c;
        if (c.st != ogr_pkg::ST_OCCUPIED) begin
            r.st = ogr_pkg::ST_EXPLORED;
            if (conf > c.conf) begin
                r.conf = conf;
            end
        end
        return r;
    endfunction

    function automatic ogr_pkg::t_cell f_clear_lm(ogr_pkg::t_cell c);
        ogr_pkg::t_cell r;
        r     = c;
        r.lm  = 1'b0;
        r.cnt = '0;
        if (c.st != ogr_pkg::ST_EXPLORED) begin
            r.st   = ogr_pkg::ST_UNKNOWN;
            r.conf = '0;
        end
        return r;
    endfunction

    // Doubled offset of a cell center from the landmark position
    function automatic logic signed [ogr_pkg::CW-1:0] f_off(
        logic [ogr_pkg::GM_W-1:0] g, logic [11:0] c, int unsigned n,
        logic signed [15:0] org, logic signed [15:0] p);
        logic [ogr_pkg::CW-1:0] ctr, nc;
        ctr = ogr_pkg::CW'({g, 1'b1}) * ogr_pkg::CW'(c);
        nc  = ogr_pkg::CW'(n) * ogr_pkg::CW'(c);
        return $signed(ctr) - $signed(nc) + ogr_pkg::CW'($signed({org, 1'b0}))
               - ogr_pkg::CW'($signed({p, 1'b0}));
    endfunction

    assign o_clearing  = (r_state == B_INIT);
    assign o_cmd_ready = (r_state == B_IDLE);
    assign w_pop       = i_cmd_valid && o_cmd_ready;
    assign w_addr      = ogr_pkg::ADDR_W'(r_y) * ogr_pkg::ADDR_W'(ogr_pkg::GRID_W)
                         + ogr_pkg::ADDR_W'(r_x);

    assign w_last_x = (r_state == B_INIT) ? (r_x == ogr_pkg::GX_W'(ogr_pkg::GRID_W - 1)) :
                                            (r_x == r_cmd.x1);
    assign w_last_y = (r_state == B_INIT) ? (r_y == ogr_pkg::GY_W'(ogr_pkg::GRID_H - 1)) :
                                            (r_y == r_cmd.y1);
    assign w_raster_done = w_last_x && w_last_y;

    // Circle test, first half: offsets and range check
    assign w_wx  = f_off(ogr_pkg::GM_W'(r_x), i_cfg.csz, ogr_pkg::GRID_W, i_cfg.org_x, r_cmd.px);
    assign w_wy  = f_off(ogr_pkg::GM_W'(r_y), i_cfg.csz, ogr_pkg::GRID_H, i_cfg.org_y, r_cmd.py);
    assign w_abx = w_wx[ogr_pkg::CW-1] ? ogr_pkg::CW'(-w_wx) : ogr_pkg::CW'(w_wx);
    assign w_aby = w_wy[ogr_pkg::CW-1] ? ogr_pkg::CW'(-w_wy) : ogr_pkg::CW'(w_wy);

    // Second half: squared distance against squared radius
    assign w_d2  = 31'(r_ax * r_ax) + 31'(r_ay * r_ay);
    assign w_hit = (r_cmd.op != ogr_pkg::OP_CIRC) || (!r_far && (w_d2 <= 31'(r_mm)));

    // Cell update
    always_comb begin
        w_wdata = r_rdata;
        w_we    = 1'b0;
        case (r_cmd.op) inside
            ogr_pkg::OP_POINT, ogr_pkg::OP_LINE, ogr_pkg::OP_RECT, ogr_pkg::OP_CIRC: begin
                w_wdata = f_mark(r_rdata, r_cmd.conf);
                w_we    = w_hit;
            end
            ogr_pkg::OP_EXPL: begin
                w_wdata = f_explore(r_rdata, r_cmd.conf);
                w_we    = 1'b1;
            end
            ogr_pkg::OP_CLR_LM: begin
                w_wdata = f_clear_lm(r_rdata);
                w_we    = 1'b1;
            end
            ogr_pkg::OP_CLR_ALL: begin
                w_wdata = '0;
                w_we    = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Walker step: Bresenham for lines, raster for areas
    always_comb begin
        w_e2  = {r_err, 1'b0};
        w_err = r_err;
        w_nx  = r_x;
        w_ny  = r_y;
        w_done = 1'b1;
        case (r_cmd.op) inside
            ogr_pkg::OP_LINE: begin
                w_done = (r_x == r_cmd.x1) && (r_y == r_cmd.y1);
                if (w_e2 > -(E_W+1)'(r_dy)) begin
                    w_err = w_err - r_dy;
                    w_nx  = r_sx ? r_x + ogr_pkg::GX_W'(1) : r_x - ogr_pkg::GX_W'(1);
                end
                if (w_e2 < (E_W+1)'(r_dx)) begin
                    w_err = w_err + r_dx;
                    w_ny  = r_sy ? r_y + ogr_pkg::GY_W'(1) : r_y - ogr_pkg::GY_W'(1);
                end
            end
            ogr_pkg::OP_RECT, ogr_pkg::OP_CIRC, ogr_pkg::OP_CLR_LM, ogr_pkg::OP_CLR_ALL: begin
                w_done = w_raster_done;
                if (w_last_x) begin
                    w_nx = r_cmd.x0;
                    w_ny = r_y + ogr_pkg::GY_W'(1);
                end else begin
                    w_nx = r_x + ogr_pkg::GX_W'(1);
                end
            end
            default: begin
                w_done = 1'b1;
            end
        endcase
    end

    assign w_load_out = (r_state == B_DONE) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_INIT: begin
                if (w_raster_done) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (w_pop) begin
                    n_state = (i_cmd.op == ogr_pkg::OP_SKIP) ? B_DONE : B_RD;
                end
            end
            B_RD: begin
                n_state = B_WR;
            end
            B_WR: begin
                n_state = w_done ? B_DONE : B_RD;
            end
            B_DONE: begin
                if (w_load_out) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_INIT;
            r_x         <= '0;
            r_y         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_INIT) begin
                if (w_last_x) begin
                    r_x <= '0;
                    r_y <= r_y + ogr_pkg::GY_W'(1);
                end else begin
                    r_x <= r_x + ogr_pkg::GX_W'(1);
                end
            end else if (w_pop) begin
                r_x <= i_cmd.x0;
                r_y <= i_cmd.y0;
            end else if (r_state == B_WR) begin
                r_x <= w_nx;
                r_y <= w_ny;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_cmd <= i_cmd;
            r_res <= '0;
            r_sx  <= (i_cmd.x0 < i_cmd.x1);
            r_sy  <= (i_cmd.y0 < i_cmd.y1);
            r_dx  <= (i_cmd.x1 > i_cmd.x0) ? E_W'(i_cmd.x1 - i_cmd.x0) :
                                             E_W'(i_cmd.x0 - i_cmd.x1);
            r_dy  <= (i_cmd.y1 > i_cmd.y0) ? E_W'(i_cmd.y1 - i_cmd.y0) :
                                             E_W'(i_cmd.y0 - i_cmd.y1);
            r_err <= ((i_cmd.x1 > i_cmd.x0) ? E_W'(i_cmd.x1 - i_cmd.x0) :
                                              E_W'(i_cmd.x0 - i_cmd.x1))
                   - ((i_cmd.y1 > i_cmd.y0) ? E_W'(i_cmd.y1 - i_cmd.y0) :
                                              E_W'(i_cmd.y0 - i_cmd.y1));
            r_mm  <= i_cmd.m * i_cmd.m;
        end
        if (r_state == B_RD) begin
            r_ax  <= w_abx[14:0];
            r_ay  <= w_aby[14:0];
            r_far <= (w_abx > ogr_pkg::CW'(32767)) || (w_aby > ogr_pkg::CW'(32767));
        end
        if (r_state == B_WR) begin
            r_err <= w_err;
            if (r_cmd.op == ogr_pkg::OP_QUERY) begin
                r_res <= r_rdata;
            end
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    // Cell memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_state == B_INIT) begin
            r_mem[w_addr] <= '0;
        end else if ((r_state == B_WR) && w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        r_rdata <= r_mem[w_addr];
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.cell_state      = r_out.st;
    assign o_rsp.has_landmark    = r_out.lm;
    assign o_rsp.landmark_count  = r_out.cnt;
    assign o_rsp.cell_confidence = r_out.conf;

endmodule

>>> rtl/occupancy_grid_rasterizer.sv
// Channel   Dir  Handshake      Word
// i_req     in   valid/ready    req_type, pos/end x y, line_has_ends, size x y, confidence
// o_rsp     out  valid/ready    cell_state, has_landmark, landmark_count, cell_confidence
// i_cfg_*   in   write enable   cell_size, origin_x, origin_y by index
//
// Sequencing: the front converts 2 to 4 coordinates (none for clears) on one shared
// serial divider, each as a load step followed by the division steps. The back visits
// each cell with a memory read, then a write.
// Reset: a clearing pass zeroes the cell memory; i_req.ready stays low.
// Stalls: a two-word command queue lets the front convert while the back walks, and the
// result register holds a word while the back moves on to the next command.
module occupancy_grid_rasterizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ogr_req_if.sink     i_req,
    ogr_rsp_if.source   o_rsp,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic [11:0]        r_cell_size;
    logic signed [15:0] r_org_x, r_org_y;
    ogr_pkg::t_cfg      w_cfg;

    ogr_pkg::t_cmd w_f_cmd, w_b_cmd;
    logic          w_f_valid, w_f_ready, w_b_valid, w_b_ready;
    logic          w_clearing;

    // Hold configuration; a zero cell size acts as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= 12'd160;
            r_org_x     <= '0;
            r_org_y     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ogr_pkg::CFG_CELL_SIZE: r_cell_size <= i_cfg_data[11:0];
                ogr_pkg::CFG_ORIGIN_X:  r_org_x     <= $signed(i_cfg_data);
                ogr_pkg::CFG_ORIGIN_Y:  r_org_y     <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign w_cfg.csz   = (r_cell_size == '0) ? 12'd1 : r_cell_size;
    assign w_cfg.org_x = r_org_x;
    assign w_cfg.org_y = r_org_y;

    // Front: accept, classify, convert world to grid
    ogr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg       (w_cfg),
        .i_hold      (w_clearing),
        .o_cmd       (w_f_cmd),
        .o_cmd_valid (w_f_valid),
        .i_cmd_ready (w_f_ready)
    );

    // Command queue between the two halves
    ogr_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_f_valid),
        .o_push_ready (w_f_ready),
        .i_data       (w_f_cmd),
        .o_pop_valid  (w_b_valid),
        .i_pop_ready  (w_b_ready),
        .o_data       (w_b_cmd)
    );

    // Back: walk cells, update memory, drive results
    ogr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd_valid (w_b_valid),
        .o_cmd_ready (w_b_ready),
        .i_cmd       (w_b_cmd),
        .o_rsp       (o_rsp),
        .o_clearing  (w_clearing)
    );

endmodule
